/* rtl/smu_pkg.sv */
// shared constants and types for the sorted union merge unit
package smu_pkg;

  localparam int LIST_DEPTH = 16;
  localparam int DATA_W = 32;
  localparam int ADDR_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int CNT_W = $clog2(LIST_DEPTH + 1);

  localparam int CMDQ_DEPTH = 2;
  localparam int CMDQ_PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
  localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

  localparam logic [1:0] MODE_LOAD_A = 2'd0;
  localparam logic [1:0] MODE_LOAD_B = 2'd1;
  localparam logic [1:0] MODE_MERGE = 2'd2;

  typedef enum logic [1:0] {
    KIND_LOAD_A,
    KIND_LOAD_B,
    KIND_MERGE
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t kind;
    logic signed [DATA_W-1:0] value;
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_MERGE = 2'b10
  } back_state_t;

endpackage

/* rtl/sorted_union_merge_unit.sv */
// top level of the sorted union merge unit
//
//   channel   handshake          words
//   input     push / full        mode, value
//   result    pop / empty        element, has_element, last, overflow
//
// a load word is taken by the back end in the cycle it reaches the head of the
// command queue, unless a merge is running. a merge walks both list rams, one
// element per cycle while the result register can take a word. rst clears
// counts, flags and queues; list contents are not cleared.
// the input keeps filling the command queue while a merge runs, and the
// result register stalls the merge walk while empty is low and pop is low.
module sorted_union_merge_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  output logic                              full,
  input  logic [1:0]                        mode,
  input  logic signed [smu_pkg::DATA_W-1:0] value,
  output logic                              empty,
  input  logic                              pop,
  output logic signed [smu_pkg::DATA_W-1:0] element,
  output logic                              has_element,
  output logic                              last,
  output logic                              overflow
);
  import smu_pkg::*;

  logic cmd_valid;
  cmd_t cmd;
  logic deq;

  smu_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .mode      (mode),
    .value     (value),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .deq       (deq)
  );

  smu_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (cmd_valid),
    .cmd         (cmd),
    .deq         (deq),
    .empty       (empty),
    .pop         (pop),
    .element     (element),
    .has_element (has_element),
    .last        (last),
    .overflow    (overflow)
  );

endmodule

/* rtl/smu_ram.sv */
// generic single write port ram with registered read
module smu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/smu_front.sv */
// front end: input decode and command queue
module smu_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  logic [1:0]                    mode,
  input  logic signed [smu_pkg::DATA_W-1:0] value,
  output logic                          cmd_valid,
  output smu_pkg::cmd_t                 cmd,
  input  logic                          deq
);
  import smu_pkg::*;

  cmd_t                  q [CMDQ_DEPTH];
  logic [CMDQ_PTR_W-1:0] wr_ptr;
  logic [CMDQ_PTR_W-1:0] rd_ptr;
  logic [CMDQ_CNT_W-1:0] count;
  logic                  enq;
  logic                  take;
  cmd_t                  dec;

  // classify the incoming word, unused mode is dropped here
  always_comb begin
    dec.value = value;
    dec.kind = KIND_LOAD_A;
    take = 1'b0;
    unique case (mode)
      MODE_LOAD_A: begin
        dec.kind = KIND_LOAD_A;
        take = 1'b1;
      end
      MODE_LOAD_B: begin
        dec.kind = KIND_LOAD_B;
        take = 1'b1;
      end
      MODE_MERGE: begin
        dec.kind = KIND_MERGE;
        take = 1'b1;
      end
      default: begin
        take = 1'b0;
      end
    endcase
  end

  assign full = (count == CMDQ_CNT_W'(CMDQ_DEPTH));
  assign enq = push && !full && take;
  assign cmd_valid = (count != '0);
  assign cmd = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (enq) begin
      q[wr_ptr] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (enq) begin
        wr_ptr <= (wr_ptr == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (deq && cmd_valid) begin
        rd_ptr <= (rd_ptr == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (enq && !(deq && cmd_valid)) begin
        count <= count + 1'b1;
      end else if (!enq && deq && cmd_valid) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* rtl/smu_back.sv */
// back end: list storage, two pointer merge walk and result register
module smu_back (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cmd_valid,
  input  smu_pkg::cmd_t                     cmd,
  output logic                              deq,
  output logic                              empty,
  input  logic                              pop,
  output logic signed [smu_pkg::DATA_W-1:0] element,
  output logic                              has_element,
  output logic                              last,
  output logic                              overflow
);
  import smu_pkg::*;

  back_state_t        state, state_next;
  logic [CNT_W-1:0]   cnt_a, cnt_a_next;
  logic [CNT_W-1:0]   cnt_b, cnt_b_next;
  logic [CNT_W-1:0]   idx_a, idx_a_next;
  logic [CNT_W-1:0]   idx_b, idx_b_next;
  logic               dropped, dropped_next;
  logic               have_prev, have_prev_next;
  logic [DATA_W-1:0]  prev, prev_next;

  logic               out_valid;
  logic               out_ready;
  logic               push_out;
  logic [DATA_W-1:0]  push_elem;
  logic               push_has;
  logic               push_last;

  logic               we_a, we_b;
  logic [DATA_W-1:0]  rd_a, rd_b;
  logic               a_ok, b_ok;
  logic [DATA_W-1:0]  pick;
  logic               emit;

  smu_ram #(.WIDTH(DATA_W), .DEPTH(LIST_DEPTH)) u_ram_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (cnt_a[ADDR_W-1:0]),
    .wdata (cmd.value),
    .raddr (idx_a_next[ADDR_W-1:0]),
    .rdata (rd_a)
  );

  smu_ram #(.WIDTH(DATA_W), .DEPTH(LIST_DEPTH)) u_ram_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (cnt_b[ADDR_W-1:0]),
    .wdata (cmd.value),
    .raddr (idx_b_next[ADDR_W-1:0]),
    .rdata (rd_b)
  );

  assign out_ready = !out_valid || pop;
  assign empty = !out_valid;
  assign deq = (state == ST_IDLE) && cmd_valid;
  assign we_a = deq && (cmd.kind == KIND_LOAD_A) && (cnt_a < CNT_W'(LIST_DEPTH));
  assign we_b = deq && (cmd.kind == KIND_LOAD_B) && (cnt_b < CNT_W'(LIST_DEPTH));
  assign a_ok = idx_a < cnt_a;
  assign b_ok = idx_b < cnt_b;

  always_comb begin
    state_next = state;
    cnt_a_next = cnt_a;
    cnt_b_next = cnt_b;
    idx_a_next = idx_a;
    idx_b_next = idx_b;
    dropped_next = dropped;
    have_prev_next = have_prev;
    prev_next = prev;
    push_out = 1'b0;
    push_elem = prev;
    push_has = 1'b1;
    push_last = 1'b0;
    pick = rd_a;
    emit = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (cmd_valid) begin
          unique case (cmd.kind)
            KIND_LOAD_A: begin
              if (we_a) begin
                cnt_a_next = cnt_a + 1'b1;
              end else begin
                dropped_next = 1'b1;
              end
            end
            KIND_LOAD_B: begin
              if (we_b) begin
                cnt_b_next = cnt_b + 1'b1;
              end else begin
                dropped_next = 1'b1;
              end
            end
            KIND_MERGE: begin
              state_next = ST_MERGE;
              have_prev_next = 1'b0;
            end
            default: begin
              state_next = ST_IDLE;
            end
          endcase
        end
      end
      ST_MERGE: begin
        if (out_ready) begin
          if (a_ok || b_ok) begin
            priority if (a_ok && b_ok) begin
              if ($signed(rd_a) <= $signed(rd_b)) begin
                pick = rd_a;
                idx_a_next = idx_a + 1'b1;
                if (rd_a == rd_b) begin
                  idx_b_next = idx_b + 1'b1;
                end
              end else begin
                pick = rd_b;
                idx_b_next = idx_b + 1'b1;
              end
            end else if (a_ok) begin
              pick = rd_a;
              idx_a_next = idx_a + 1'b1;
            end else begin
              pick = rd_b;
              idx_b_next = idx_b + 1'b1;
            end
            emit = !have_prev || (prev != pick);
            // the held value goes out once a newer one replaces it
            if (emit) begin
              push_out = have_prev;
              prev_next = pick;
              have_prev_next = 1'b1;
            end
          end else begin
            push_out = 1'b1;
            push_elem = have_prev ? prev : '0;
            push_has = have_prev;
            push_last = 1'b1;
            cnt_a_next = '0;
            cnt_b_next = '0;
            idx_a_next = '0;
            idx_b_next = '0;
            dropped_next = 1'b0;
            have_prev_next = 1'b0;
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt_a <= '0;
      cnt_b <= '0;
      idx_a <= '0;
      idx_b <= '0;
      dropped <= 1'b0;
      have_prev <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt_a <= cnt_a_next;
      cnt_b <= cnt_b_next;
      idx_a <= idx_a_next;
      idx_b <= idx_b_next;
      dropped <= dropped_next;
      have_prev <= have_prev_next;
      if (push_out) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    prev <= prev_next;
    if (push_out) begin
      element <= push_elem;
      has_element <= push_has;
      last <= push_last;
      overflow <= dropped;
    end
  end

endmodule

/* tb/tb_sorted_union_merge_unit.sv */
// testbench for the sorted union merge unit: random load and merge words checked against a union predictor
module tb_sorted_union_merge_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import smu_pkg::*;

  localparam logic [1:0] MODE_NOP = 2'd3;
  localparam int         N_WORDS = 470;

  typedef struct packed {
    logic [1:0]               mode;
    logic signed [DATA_W-1:0] value;
  } in_word_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] element;
    logic                     has_element;
    logic                     last;
    logic                     overflow;
  } union_word_t;

  logic                     clk;
  logic                     rst = 1'b1;
  logic                     push = 1'b0;
  logic                     full;
  logic [1:0]               mode = MODE_LOAD_A;
  logic signed [DATA_W-1:0] value = '0;
  logic                     empty;
  logic                     pop = 1'b0;
  logic signed [DATA_W-1:0] element;
  logic                     has_element;
  logic                     last;
  logic                     overflow;

  sorted_union_merge_unit i_dut (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .mode        (mode),
    .value       (value),
    .empty       (empty),
    .pop         (pop),
    .element     (element),
    .has_element (has_element),
    .last        (last),
    .overflow    (overflow)
  );

  in_word_t    word_feed[$];
  union_word_t union_expect[$];

  logic signed [DATA_W-1:0] list_a[LIST_DEPTH];
  logic signed [DATA_W-1:0] list_b[LIST_DEPTH];
  int count_a = 0;
  int count_b = 0;
  bit dropped = 1'b0;

  int errors = 0;
  int n_gen = 0;
  int n_accepted = 0;
  int n_loads = 0;
  int n_drops = 0;
  int n_merges = 0;
  int n_ignored = 0;
  int n_checked = 0;
  bit in_taken = 1'b0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // predictor: list state plus the expected union of each merge
  task automatic track_union_word(input logic [1:0] m, input logic signed [DATA_W-1:0] v);
    int i;
    int j;
    bit have_prev;
    bit have_held;
    logic signed [DATA_W-1:0] prev;
    logic signed [DATA_W-1:0] pick;
    union_word_t held;
    case (m)
      MODE_LOAD_A, MODE_LOAD_B: begin
        n_loads++;
        if (m == MODE_LOAD_A && count_a < LIST_DEPTH) begin
          list_a[count_a] = v;
          count_a++;
        end else if (m == MODE_LOAD_B && count_b < LIST_DEPTH) begin
          list_b[count_b] = v;
          count_b++;
        end else begin
          dropped = 1'b1;
          n_drops++;
        end
      end
      MODE_MERGE: begin
        n_merges++;
        i = 0;
        j = 0;
        have_prev = 1'b0;
        have_held = 1'b0;
        prev = '0;
        held = '0;
        while (i < count_a || j < count_b) begin
          if (i < count_a && (j >= count_b || list_a[i] <= list_b[j])) begin
            pick = list_a[i];
            if (j < count_b && list_a[i] == list_b[j]) j++;
            i++;
          end else begin
            pick = list_b[j];
            j++;
          end
          if (!have_prev || pick != prev) begin
            if (have_held) union_expect.insert(union_expect.size(), held);
            held = '{element: pick, has_element: 1'b1, last: 1'b0, overflow: dropped};
            have_held = 1'b1;
            prev = pick;
            have_prev = 1'b1;
          end
        end
        if (!have_held) held = '{element: '0, has_element: 1'b0, last: 1'b0, overflow: dropped};
        held.last = 1'b1;
        union_expect.insert(union_expect.size(), held);
        count_a = 0;
        count_b = 0;
        dropped = 1'b0;
      end
      default: n_ignored++;
    endcase
  endtask

  task automatic add_word(input logic [1:0] m, input logic signed [DATA_W-1:0] v);
    in_word_t w;
    w.mode = m;
    w.value = v;
    word_feed.insert(word_feed.size(), w);
    if (m != MODE_NOP) n_gen++;
  endtask

  // one list of n values, sorted unless noisy
  task automatic make_list(input int n, input bit noisy,
                           output logic signed [DATA_W-1:0] vals[20]);
    longint acc;
    int span;
    int k;
    span = $urandom_range(0, 3);
    if (span == 3) acc = -64'sd2147483648 + longint'($urandom_range(0, 1 << 30));
    else if (span == 2) acc = longint'($signed($urandom));
    else acc = longint'($urandom_range(0, 40)) - 20;
    for (k = 0; k < n; k++) begin
      if (noisy) vals[k] = $signed($urandom);
      else begin
        case (span)
          0: acc = acc + $urandom_range(0, 1);
          1: acc = acc + $urandom_range(0, 4);
          default: acc = acc + $urandom_range(0, 1 << 28);
        endcase
        if (acc > 64'sd2147483647) acc = 64'sd2147483647;
        vals[k] = acc[DATA_W-1:0];
      end
    end
  endtask

  task automatic add_merge_set();
    logic signed [DATA_W-1:0] vals_a[20];
    logic signed [DATA_W-1:0] vals_b[20];
    int na;
    int nb;
    int ia;
    int ib;
    bit noisy;
    noisy = ($urandom_range(0, 7) == 0);
    na = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 20) : $urandom_range(0, 16);
    nb = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 20) : $urandom_range(0, 16);
    if ($urandom_range(0, 3) == 0) na = $urandom_range(0, 3);
    make_list(na, noisy, vals_a);
    make_list(nb, noisy, vals_b);
    ia = 0;
    ib = 0;
    while (ia < na || ib < nb) begin
      if ($urandom_range(0, 24) == 0) add_word(MODE_NOP, $signed($urandom));
      if (ib >= nb || (ia < na && $urandom_range(0, 1) == 0)) begin
        add_word(MODE_LOAD_A, vals_a[ia]);
        ia++;
      end else begin
        add_word(MODE_LOAD_B, vals_b[ib]);
        ib++;
      end
    end
    add_word(MODE_MERGE, $signed($urandom));
  endtask

  // monitor and predictor update
  always @(posedge clk) begin
    union_word_t exp_w;
    in_taken = !rst && push && !full;
    if (in_taken) begin
      n_accepted++;
      track_union_word(mode, value);
    end
    if (!rst && pop && !empty) begin
      if (union_expect.size() == 0) begin
        $error("unexpected result word: element %0d has_element %0b last %0b overflow %0b",
               element, has_element, last, overflow);
        errors++;
      end else begin
        exp_w = union_expect.pop_front();
        n_checked++;
        if (has_element !== exp_w.has_element) begin
          $error("has_element: expected %0b, got %0b", exp_w.has_element, has_element);
          errors++;
        end
        if (element !== exp_w.element) begin
          $error("element: expected %0d, got %0d", exp_w.element, element);
          errors++;
        end
        if (last !== exp_w.last) begin
          $error("last: expected %0b, got %0b", exp_w.last, last);
          errors++;
        end
        if (overflow !== exp_w.overflow) begin
          $error("overflow: expected %0b, got %0b", exp_w.overflow, overflow);
          errors++;
        end
      end
    end
  end

  // driver with bursts and gaps
  int burst_left = 1;
  int gap_left = 0;
  always @(negedge clk) begin
    in_word_t w;
    if (!rst && !(push && !in_taken)) begin
      if (gap_left > 0) begin
        gap_left--;
        push <= 1'b0;
      end else if (word_feed.size() > 0) begin
        w = word_feed.pop_front();
        push <= 1'b1;
        mode <= w.mode;
        value <= w.value;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        push <= 1'b0;
      end
    end
  end

  // receiver stall pattern, plus one long hold-off to back up the input
  int hold_left = 0;
  bit hold_done = 1'b0;
  int phase_left = 0;
  int pop_pct = 100;
  always @(negedge clk) begin
    if (!rst) begin
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (!hold_done && n_accepted >= 120) begin
        hold_done = 1'b1;
        hold_left = 400;
        pop <= 1'b0;
      end else begin
        if (phase_left <= 0) begin
          phase_left = $urandom_range(10, 80);
          case ($urandom_range(0, 2))
            0: pop_pct = 100;
            1: pop_pct = 60;
            default: pop_pct = 25;
          endcase
        end
        phase_left--;
        pop <= ($urandom_range(0, 99) < pop_pct);
      end
    end
  end

  initial begin
    int k;
    // merge of two empty lists
    add_word(MODE_MERGE, '0);
    // field extremes and equal heads
    add_word(MODE_LOAD_A, 32'sh8000_0000);
    add_word(MODE_LOAD_B, 32'sh8000_0000);
    add_word(MODE_LOAD_B, 32'sd5);
    add_word(MODE_LOAD_A, 32'sh7fff_ffff);
    add_word(MODE_LOAD_B, 32'sh7fff_ffff);
    add_word(MODE_MERGE, 32'sh7fff_ffff);
    // ignored mode, then a full list with a dropped load
    add_word(MODE_NOP, 32'sh8000_0000);
    for (k = 0; k < LIST_DEPTH + 1; k++) add_word(MODE_LOAD_B, 2 * k - 16);
    add_word(MODE_MERGE, '0);
    while (n_gen < N_WORDS) add_merge_set();

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (word_feed.size() != 0 || push) @(posedge clk);
    while (union_expect.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    $display("covered %0d load words (%0d dropped on a full list), %0d merges, %0d ignored words",
             n_loads, n_drops, n_merges, n_ignored);
    $display("checked %0d union words with %0d mismatches", n_checked, errors);
    if (errors == 0) begin
      $display("tb_sorted_union_merge_unit: PASS");
    end else begin
      $display("tb_sorted_union_merge_unit: FAIL");
    end
    $finish;
  end

  initial begin
    #2_400_000;
    $display("timeout with %0d words still expected", union_expect.size());
    $display("tb_sorted_union_merge_unit: FAIL");
    $finish;
  end

endmodule

/* filelist.f */
rtl/smu_pkg.sv
rtl/smu_ram.sv
rtl/smu_front.sv
rtl/smu_back.sv
rtl/sorted_union_merge_unit.sv
tb/tb_sorted_union_merge_unit.sv
